### rtl/spe_pkg.sv
// shared types and constants for the set partition enumerator
package spe_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int FLD_W        = 5;
    localparam int SIZE_RESET   = 4;
    localparam int IN_DATA_W    = 8;
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_USER_W   = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_LOAD,
        ST_EMIT,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic find;
        logic load;
        logic emit;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic block_end;
        logic run_end;
    } sts_t;

endpackage

### rtl/set_partition_enumerator.sv
// top level of the set partition enumerator
//
//  channel | direction | tdata / tuser / tlast contents
//  --------+-----------+-----------------------------------------------------------
//  s_      | in        | tdata[0] restart, [7:1] zero
//  m_      | out       | tdata[4:0] element_number, [9:5] block_number, [15:10] zero;
//          |           |   tuser[0] last_in_block, [1] final_partition;
//          |           |   tlast last_of_run
//  cfg_    | in        | wdata[4:0] set_size, written when cfg_we is high
//
// one request transaction yields n result transactions (n elements): a pivot
// search, one mask load per block, one emit per element and one update step
// reset loads set_size 4 and the first partition (every element in block 1)
// a stalled m_ side holds the emit sequence in place; s_tready stays low until
// the partition has been advanced
module set_partition_enumerator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [spe_pkg::IN_DATA_W-1:0]   s_tdata,   // [0] restart
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [spe_pkg::OUT_DATA_W-1:0]  m_tdata,   // element_number, block_number
    output logic [spe_pkg::OUT_USER_W-1:0]  m_tuser,   // last_in_block, final_partition
    output logic                            m_tlast,   // last_of_run
    // configuration
    input  logic                            cfg_we,
    input  logic [spe_pkg::FLD_W-1:0]       cfg_wdata  // set_size
);

    spe_pkg::cmd_t              cmd;
    spe_pkg::sts_t              sts;
    logic [spe_pkg::FLD_W-1:0]  element_number;
    logic [spe_pkg::FLD_W-1:0]  block_number;
    logic                       last_in_block;
    logic                       final_partition;

    // sequencer: accept, pivot search, per-block load, emit, advance
    spe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // label store and result generation
    spe_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .restart         (s_tdata[0]),
        .cmd             (cmd),
        .sts             (sts),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .element_number  (element_number),
        .block_number    (block_number),
        .last_in_block   (last_in_block),
        .last_of_run     (m_tlast),
        .final_partition (final_partition)
    );

    // pack result fields, lowest first, zero fill to a whole number of bytes
    assign m_tdata = {{(spe_pkg::OUT_DATA_W - 2 * spe_pkg::FLD_W){1'b0}},
                      block_number, element_number};
    assign m_tuser = {final_partition, last_in_block};

endmodule

### rtl/spe_ctrl.sv
// sequencing state machine for the set partition enumerator
module spe_ctrl (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  spe_pkg::sts_t sts,
    output spe_pkg::cmd_t cmd
);

    spe_pkg::state_t state_reg;
    spe_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            spe_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = spe_pkg::ST_FIND;
                end
            end
            spe_pkg::ST_FIND: begin
                cmd.find   = 1'b1;
                state_next = spe_pkg::ST_LOAD;
            end
            spe_pkg::ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = spe_pkg::ST_EMIT;
            end
            spe_pkg::ST_EMIT: begin
                cmd.emit = 1'b1;
                if (sts.run_end) begin
                    state_next = spe_pkg::ST_UPDATE;
                end else if (sts.block_end) begin
                    state_next = spe_pkg::ST_LOAD;
                end
            end
            spe_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = spe_pkg::ST_IDLE;
            end
            default: begin
                state_next = spe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/spe_dp.sv
// label store, pivot search, block emission and output register
module spe_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [spe_pkg::FLD_W-1:0]   cfg_wdata,
    input  logic                        restart,
    input  spe_pkg::cmd_t               cmd,
    output spe_pkg::sts_t               sts,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [spe_pkg::FLD_W-1:0]   element_number,
    output logic [spe_pkg::FLD_W-1:0]   block_number,
    output logic                        last_in_block,
    output logic                        last_of_run,
    output logic                        final_partition
);

    logic [spe_pkg::FLD_W-1:0]        size_reg;
    logic [spe_pkg::FLD_W-1:0]        label_reg [spe_pkg::MAX_ELEMENTS];
    logic [spe_pkg::FLD_W-1:0]        max_reg   [spe_pkg::MAX_ELEMENTS];
    logic [spe_pkg::IDX_W-1:0]        pivot_reg;
    logic                             final_reg;
    logic [spe_pkg::FLD_W-1:0]        blk_reg;
    logic [spe_pkg::MAX_ELEMENTS-1:0] rem_reg;
    logic [spe_pkg::CNT_W-1:0]        cnt_reg;

    logic                             m_valid_reg;
    logic [spe_pkg::FLD_W-1:0]        m_elem_reg;
    logic [spe_pkg::FLD_W-1:0]        m_blk_reg;
    logic                             m_lib_reg;
    logic                             m_last_reg;
    logic                             m_final_reg;

    logic [spe_pkg::CNT_W-1:0]        n;
    logic                             pivot_found;
    logic [spe_pkg::IDX_W-1:0]        pivot_idx;
    logic [spe_pkg::MAX_ELEMENTS-1:0] blk_mask;
    logic [spe_pkg::IDX_W-1:0]        low_idx;
    logic                             rem_single;
    logic                             run_last;
    logic                             fire;
    logic                             go_first;
    logic [spe_pkg::FLD_W-1:0]        lbl_p;
    logic [spe_pkg::FLD_W-1:0]        max_p;
    logic [spe_pkg::FLD_W-1:0]        lbl_new;
    logic [spe_pkg::FLD_W-1:0]        max_new;

    // effective set size, clamped to 1..MAX_ELEMENTS
    always_comb begin
        if (size_reg == '0) begin
            n = spe_pkg::CNT_W'(1);
        end else if (int'(size_reg) > spe_pkg::MAX_ELEMENTS) begin
            n = spe_pkg::CNT_W'(spe_pkg::MAX_ELEMENTS);
        end else begin
            n = spe_pkg::CNT_W'(size_reg);
        end
    end

    // rightmost growable position in 1..n-1
    always_comb begin
        pivot_found = 1'b0;
        pivot_idx   = '0;
        for (int i = 1; i < spe_pkg::MAX_ELEMENTS; i++) begin
            if (spe_pkg::CNT_W'(i) < n && label_reg[i] < max_reg[i]) begin
                pivot_found = 1'b1;
                pivot_idx   = spe_pkg::IDX_W'(i);
            end
        end
    end

    // members of the current block
    always_comb begin
        for (int j = 0; j < spe_pkg::MAX_ELEMENTS; j++) begin
            blk_mask[j] = (spe_pkg::CNT_W'(j) < n) && (label_reg[j] == blk_reg);
        end
    end

    // lowest remaining member
    always_comb begin
        low_idx = '0;
        for (int j = spe_pkg::MAX_ELEMENTS - 1; j >= 0; j--) begin
            if (rem_reg[j]) begin
                low_idx = spe_pkg::IDX_W'(j);
            end
        end
    end

    assign rem_single = ((rem_reg & (rem_reg - spe_pkg::MAX_ELEMENTS'(1))) == '0);
    assign run_last   = (cnt_reg + spe_pkg::CNT_W'(1)) == n;
    assign fire       = cmd.emit && (!m_valid_reg || m_tready);

    assign sts.block_end = fire && rem_single;
    assign sts.run_end   = fire && run_last;

    assign go_first = cfg_we || (cmd.accept && restart) || (cmd.update && final_reg);

    assign lbl_p   = label_reg[pivot_reg];
    assign max_p   = max_reg[pivot_reg];
    assign lbl_new = lbl_p + spe_pkg::FLD_W'(1);
    assign max_new = max_p + ((lbl_new == max_p) ? spe_pkg::FLD_W'(1) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= spe_pkg::FLD_W'(spe_pkg::SIZE_RESET);
            for (int j = 0; j < spe_pkg::MAX_ELEMENTS; j++) begin
                label_reg[j] <= spe_pkg::FLD_W'(1);
                max_reg[j]   <= spe_pkg::FLD_W'(2);
            end
        end else begin
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (go_first) begin
                for (int j = 0; j < spe_pkg::MAX_ELEMENTS; j++) begin
                    label_reg[j] <= spe_pkg::FLD_W'(1);
                    max_reg[j]   <= spe_pkg::FLD_W'(2);
                end
            end else if (cmd.update) begin
                label_reg[pivot_reg] <= lbl_new;
                for (int j = 0; j < spe_pkg::MAX_ELEMENTS; j++) begin
                    if (spe_pkg::IDX_W'(j) > pivot_reg && spe_pkg::CNT_W'(j) < n) begin
                        label_reg[j] <= spe_pkg::FLD_W'(1);
                        max_reg[j]   <= max_new;
                    end
                end
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            blk_reg <= spe_pkg::FLD_W'(1);
            cnt_reg <= '0;
        end
        if (cmd.find) begin
            pivot_reg <= pivot_idx;
            final_reg <= !pivot_found;
        end
        if (cmd.load) begin
            rem_reg <= blk_mask;
        end
        if (fire) begin
            rem_reg[low_idx] <= 1'b0;
            cnt_reg          <= cnt_reg + spe_pkg::CNT_W'(1);
            if (rem_single) begin
                blk_reg <= blk_reg + spe_pkg::FLD_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_elem_reg  <= spe_pkg::FLD_W'(32'(low_idx) + 32'd1);
            m_blk_reg   <= blk_reg;
            m_lib_reg   <= rem_single;
            m_last_reg  <= run_last;
            m_final_reg <= final_reg;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign element_number  = m_elem_reg;
    assign block_number    = m_blk_reg;
    assign last_in_block   = m_lib_reg;
    assign last_of_run     = m_last_reg;
    assign final_partition = m_final_reg;

endmodule
